// ----- rtl/core/predictive_info_histogram_macros.svh -----
// ----------------------------------------------------------------------------
// predictive_info_histogram_macros: assertion shorthands
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PREDICTIVE_INFO_HISTOGRAM_MACROS_SVH
`define PREDICTIVE_INFO_HISTOGRAM_MACROS_SVH

// same-cycle implication
`define PIH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("predictive_info_histogram: same-cycle check failed");

// next-cycle implication
`define PIH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("predictive_info_histogram: next-cycle check failed");

`endif

// ----- rtl/core/pih_pkg.sv -----
// ----------------------------------------------------------------------------
// pih_pkg: shared types and constants
// opcodes, register indexes, control states and coder handshake structs
// ----------------------------------------------------------------------------
package pih_pkg;

    // fixed field widths of the channels
    localparam int OPC_W      = 2;
    localparam int SYM_W      = 8;
    localparam int RIDX_W     = 12;
    localparam int CODE_W     = 12;
    localparam int CNT_OUT_W  = 32;
    localparam int BASE_CFG_W = 5;
    localparam int LEN_CFG_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE   = 2'd0,
        CFG_PAST   = 2'd1,
        CFG_FUTURE = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BAD,
        ST_CODE,
        ST_UPDATE
    } state_t;

    // control into the window coder
    typedef struct packed {
        logic push;
        logic restart;
    } coder_cmd_t;

    // status back from the window coder
    typedef struct packed {
        logic window_full;
        logic done;
    } coder_sts_t;

endpackage

// ----- rtl/core/pih_if.sv -----
// ----------------------------------------------------------------------------
// pih_if: request and result channels
// valid/ready handshake with payload
// ----------------------------------------------------------------------------
interface pih_req_if;
    import pih_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [SYM_W-1:0]  symbol;
    logic              first_of_series;
    logic [RIDX_W-1:0] read_index;

    modport source (
        output valid, opcode, symbol, first_of_series, read_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, symbol, first_of_series, read_index,
        output ready
    );
endinterface

interface pih_rsp_if;
    import pih_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CODE_W-1:0]    joint_code;
    logic [CODE_W-1:0]    history_code;
    logic [CODE_W-1:0]    future_code;
    logic [CNT_OUT_W-1:0] joint_count;
    logic [CNT_OUT_W-1:0] history_count;
    logic [CNT_OUT_W-1:0] future_count;
    logic [CNT_OUT_W-1:0] window_total;
    logic                 bad_symbol;

    modport source (
        output valid, joint_code, history_code, future_code, joint_count,
               history_count, future_count, window_total, bad_symbol,
        input  ready
    );
    modport sink (
        input  valid, joint_code, history_code, future_code, joint_count,
               history_count, future_count, window_total, bad_symbol,
        output ready
    );
endinterface

// ----- rtl/core/pih_ram.sv -----
// ----------------------------------------------------------------------------
// pih_ram: generic synchronous RAM
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pih_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/pih_coder.sv -----
// ----------------------------------------------------------------------------
// pih_coder: symbol window and code sequencer
// shift register of recent digits, horner evaluation one digit per cycle
// ----------------------------------------------------------------------------
module pih_coder #(
    parameter int MAX_WINDOW = 12,
    parameter int MAX_BASE   = 16,
    parameter int ADDR_BITS  = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pih_pkg::coder_cmd_t               cmd,
    input  logic [$clog2(MAX_BASE)-1:0]       digit,
    input  logic [$clog2(MAX_BASE+1)-1:0]     base_eff,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]   kf,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]   len,
    output pih_pkg::coder_sts_t               sts,
    output logic [ADDR_BITS-1:0]              joint_code,
    output logic [ADDR_BITS-1:0]              history_code,
    output logic [ADDR_BITS-1:0]              future_code
);
    import pih_pkg::*;

    localparam int DIG_W = $clog2(MAX_BASE);
    localparam int LEN_W = $clog2(MAX_WINDOW+1);
    localparam int IDX_W = $clog2(MAX_WINDOW);

    logic [DIG_W-1:0]     win_reg  [MAX_WINDOW];
    logic [DIG_W-1:0]     win_next [MAX_WINDOW];
    logic [LEN_W-1:0]     fill_reg, fill_next;
    logic [LEN_W-1:0]     fill_base, fill_inc;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [ADDR_BITS-1:0] jacc_reg, jacc_next;
    logic [ADDR_BITS-1:0] hacc_reg, hacc_next;
    logic [ADDR_BITS-1:0] facc_reg, facc_next;
    logic [DIG_W-1:0]     digit_sel;
    logic [ADDR_BITS-1:0] jstep, fstep;
    logic                 full_after;

    // fill level after this request
    always_comb
    begin
        fill_base  = cmd.restart ? '0 : fill_reg;
        fill_inc   = (fill_base == LEN_W'(MAX_WINDOW)) ? fill_base : fill_base + LEN_W'(1);
        full_after = (fill_inc >= len);
        fill_next  = fill_reg;
        if (cmd.push)
        begin
            fill_next = fill_inc;
        end
        else if (cmd.restart)
        begin
            fill_next = '0;
        end
    end

    // newest digit at index 0
    always_comb
    begin
        win_next = win_reg;
        if (cmd.push)
        begin
            for (int i = MAX_WINDOW - 1; i > 0; i--)
            begin
                win_next[i] = win_reg[i-1];
            end
            win_next[0] = digit;
        end
    end

    // horner step, oldest digit first, codes kept modulo the table size
    always_comb
    begin
        digit_sel = win_reg[idx_reg];
        jstep     = jacc_reg * ADDR_BITS'(base_eff) + ADDR_BITS'(digit_sel);
        fstep     = facc_reg * ADDR_BITS'(base_eff) + ADDR_BITS'(digit_sel);
        run_next  = run_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        jacc_next = jacc_reg;
        hacc_next = hacc_reg;
        facc_next = facc_reg;
        if (cmd.push && full_after)
        begin
            run_next  = 1'b1;
            idx_next  = IDX_W'(len - LEN_W'(1));
            jacc_next = '0;
            facc_next = '0;
        end
        else if (run_reg)
        begin
            jacc_next = jstep;
            if (LEN_W'(idx_reg) < kf)
            begin
                facc_next = fstep;
            end
            if (LEN_W'(idx_reg) == kf)
            begin
                hacc_next = jstep;
            end
            if (idx_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        jacc_reg <= jacc_next;
        hacc_reg <= hacc_next;
        facc_reg <= facc_next;
    end

    assign sts.window_full = full_after;
    assign sts.done        = done_reg;
    assign joint_code      = jacc_reg;
    assign history_code    = hacc_reg;
    assign future_code     = facc_reg;

endmodule

// ----- rtl/core/predictive_info_histogram.sv -----
// ----------------------------------------------------------------------------
// predictive_info_histogram: sliding-window joint histogram
// three count tables in RAM, updated by read-modify-write per full window
// ----------------------------------------------------------------------------
//
//  channel   kind        payload
//  --------  ----------  ----------------------------------------------------
//  req       valid/ready opcode, symbol, first_of_series, read_index
//  rsp       valid/ready codes, three counts, window_total, bad_symbol
//  cfg       write only  cfg_write, cfg_index, cfg_data
//
//  one request at a time; a push that completes a window runs one horner
//  step per cycle over len = past+future digits, then RAM read and write-back;
//  other good pushes stay in idle, a bad symbol passes ST_BAD, a read ST_UPDATE
//  clear request and reset both run a zeroing pass over all 2^TABLE_ADDR_BITS
//  entries of the three tables, during which req.ready stays low
//  a finished result waits in the output register; the next request is taken
//  meanwhile and only stalls when it has its own result to place
//
module predictive_info_histogram #(
    parameter int TABLE_ADDR_BITS = 12,
    parameter int MAX_WINDOW      = 12,
    parameter int COUNT_BITS      = 32,
    parameter int MAX_BASE        = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pih_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pih_pkg::CFG_DATA_W-1:0] cfg_data,
    pih_req_if.sink                       req,
    pih_rsp_if.source                     rsp
);
    import pih_pkg::*;

    localparam int A_W    = TABLE_ADDR_BITS;
    localparam int DEPTH  = 1 << TABLE_ADDR_BITS;
    localparam int BASE_W = $clog2(MAX_BASE+1);
    localparam int LEN_W  = $clog2(MAX_WINDOW+1);
    localparam int DIG_W  = $clog2(MAX_BASE);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    // configuration registers
    logic [BASE_CFG_W-1:0] cfg_base_reg;
    logic [LEN_CFG_W-1:0]  cfg_past_reg;
    logic [LEN_CFG_W-1:0]  cfg_future_reg;

    // effective (clamped) settings
    logic [BASE_W-1:0] base_eff;
    logic [LEN_W-1:0]  kp, kf, len;

    // control
    state_t              state_reg, state_next;
    logic [A_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                is_read_reg, is_read_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                out_free;
    logic                sym_bad;
    logic                req_ready;

    // result register
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [CODE_W-1:0]    jcode_reg, jcode_next;
    logic [CODE_W-1:0]    hcode_reg, hcode_next;
    logic [CODE_W-1:0]    fcode_reg, fcode_next;
    logic [CNT_OUT_W-1:0] jcnt_reg, jcnt_next;
    logic [CNT_OUT_W-1:0] hcnt_reg, hcnt_next;
    logic [CNT_OUT_W-1:0] fcnt_reg, fcnt_next;
    logic [CNT_OUT_W-1:0] wtot_reg, wtot_next;
    logic                 bad_reg, bad_next;

    // coder
    coder_cmd_t     coder_cmd;
    coder_sts_t     coder_sts;
    logic [A_W-1:0] joint_code, history_code, future_code;

    // tables
    logic                  tab_re, tab_we, tab_clear, rd_from_req;
    logic [A_W-1:0]        j_raddr, h_raddr, f_raddr;
    logic [A_W-1:0]        j_waddr, h_waddr, f_waddr;
    logic [COUNT_BITS-1:0] j_rdata, h_rdata, f_rdata;
    logic [COUNT_BITS-1:0] j_inc, h_inc, f_inc, total_inc;

    // ------------------------------------------------------------------
    // configuration port, writes past the register list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg   <= BASE_CFG_W'(2);
            cfg_past_reg   <= LEN_CFG_W'(1);
            cfg_future_reg <= LEN_CFG_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BASE:   cfg_base_reg   <= BASE_CFG_W'(cfg_data);
                CFG_PAST:   cfg_past_reg   <= LEN_CFG_W'(cfg_data);
                CFG_FUTURE: cfg_future_reg <= LEN_CFG_W'(cfg_data);
                default:    ;
            endcase
        end
    end

    // clamp base to 2..MAX_BASE, past to 1..MAX_WINDOW-1,
    // future to 1..MAX_WINDOW-past
    always_comb
    begin
        if (int'(cfg_base_reg) < 2)
        begin
            base_eff = BASE_W'(2);
        end
        else if (int'(cfg_base_reg) > MAX_BASE)
        begin
            base_eff = BASE_W'(MAX_BASE);
        end
        else
        begin
            base_eff = BASE_W'(cfg_base_reg);
        end

        if (cfg_past_reg == '0)
        begin
            kp = LEN_W'(1);
        end
        else if (int'(cfg_past_reg) > MAX_WINDOW - 1)
        begin
            kp = LEN_W'(MAX_WINDOW - 1);
        end
        else
        begin
            kp = LEN_W'(cfg_past_reg);
        end

        if (cfg_future_reg == '0)
        begin
            kf = LEN_W'(1);
        end
        else if (int'(cfg_future_reg) > MAX_WINDOW - int'(kp))
        begin
            kf = LEN_W'(MAX_WINDOW) - kp;
        end
        else
        begin
            kf = LEN_W'(cfg_future_reg);
        end

        len = kp + kf;
    end

    assign sym_bad  = int'(req.symbol) >= int'(base_eff);
    assign out_free = !rsp_valid_reg || rsp.ready;

    // ------------------------------------------------------------------
    // window and code sequencer
    // ------------------------------------------------------------------
    // window commands straight from an accepted push;
    // a new series empties the window even for a bad symbol
    always_comb
    begin
        coder_cmd = '0;
        if (state_reg == ST_IDLE && req.valid && req.opcode == OP_PUSH)
        begin
            coder_cmd.restart = req.first_of_series;
            coder_cmd.push    = !sym_bad;
        end
    end

    pih_coder #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_BASE   (MAX_BASE),
        .ADDR_BITS  (A_W)
    ) u_coder (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (coder_cmd),
        .digit        (DIG_W'(req.symbol)),
        .base_eff     (base_eff),
        .kf           (kf),
        .len          (len),
        .sts          (coder_sts),
        .joint_code   (joint_code),
        .history_code (history_code),
        .future_code  (future_code)
    );

    // saturating increments of the data just read back
    assign j_inc     = sat_inc(j_rdata);
    assign h_inc     = sat_inc(h_rdata);
    assign f_inc     = sat_inc(f_rdata);
    assign total_inc = sat_inc(total_reg);

    // ------------------------------------------------------------------
    // control: one request in flight, RAM read issued in the state before
    // the write-back, so a later read never overlaps an earlier update
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        is_read_next   = is_read_reg;
        total_next     = total_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        jcode_next     = jcode_reg;
        hcode_next     = hcode_reg;
        fcode_next     = fcode_reg;
        jcnt_next      = jcnt_reg;
        hcnt_next      = hcnt_reg;
        fcnt_next      = fcnt_reg;
        wtot_next      = wtot_reg;
        bad_next       = bad_reg;
        tab_re         = 1'b0;
        tab_we         = 1'b0;
        tab_clear      = 1'b0;
        rd_from_req    = 1'b0;
        req_ready      = 1'b0;

        unique case (state_reg)
            // zeroing pass, one entry of each table per cycle
            ST_CLEAR:
            begin
                tab_we       = 1'b1;
                tab_clear    = 1'b1;
                clr_cnt_next = clr_cnt_reg + A_W'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    unique case (req.opcode)
                        OP_PUSH:
                        begin
                            if (sym_bad)
                            begin
                                state_next = ST_BAD;
                            end
                            else if (coder_sts.window_full)
                            begin
                                state_next = ST_CODE;
                            end
                        end
                        OP_READ:
                        begin
                            tab_re       = 1'b1;
                            rd_from_req  = 1'b1;
                            is_read_next = 1'b1;
                            state_next   = ST_UPDATE;
                        end
                        OP_CLEAR:
                        begin
                            total_next   = '0;
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end

            ST_BAD:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    jcode_next     = '0;
                    hcode_next     = '0;
                    fcode_next     = '0;
                    jcnt_next      = '0;
                    hcnt_next      = '0;
                    fcnt_next      = '0;
                    wtot_next      = CNT_OUT_W'(total_reg);
                    bad_next       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // wait for the three codes, then fetch the counts
            ST_CODE:
            begin
                if (coder_sts.done)
                begin
                    tab_re       = 1'b1;
                    is_read_next = 1'b0;
                    state_next   = ST_UPDATE;
                end
            end

            // read data held by the RAMs until the result slot frees up
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    bad_next       = 1'b0;
                    state_next     = ST_IDLE;
                    if (is_read_reg)
                    begin
                        jcode_next = '0;
                        hcode_next = '0;
                        fcode_next = '0;
                        jcnt_next  = CNT_OUT_W'(j_rdata);
                        hcnt_next  = CNT_OUT_W'(h_rdata);
                        fcnt_next  = CNT_OUT_W'(f_rdata);
                        wtot_next  = CNT_OUT_W'(total_reg);
                    end
                    else
                    begin
                        tab_we     = 1'b1;
                        total_next = total_inc;
                        jcode_next = CODE_W'(joint_code);
                        hcode_next = CODE_W'(history_code);
                        fcode_next = CODE_W'(future_code);
                        jcnt_next  = CNT_OUT_W'(j_inc);
                        hcnt_next  = CNT_OUT_W'(h_inc);
                        fcnt_next  = CNT_OUT_W'(f_inc);
                        wtot_next  = CNT_OUT_W'(total_inc);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            is_read_reg   <= 1'b0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            is_read_reg   <= is_read_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jcode_reg <= jcode_next;
        hcode_reg <= hcode_next;
        fcode_reg <= fcode_next;
        jcnt_reg  <= jcnt_next;
        hcnt_reg  <= hcnt_next;
        fcnt_reg  <= fcnt_next;
        wtot_reg  <= wtot_next;
        bad_reg   <= bad_next;
    end

    // ------------------------------------------------------------------
    // count tables
    // ------------------------------------------------------------------
    assign j_raddr = rd_from_req ? A_W'(req.read_index) : joint_code;
    assign h_raddr = rd_from_req ? A_W'(req.read_index) : history_code;
    assign f_raddr = rd_from_req ? A_W'(req.read_index) : future_code;
    assign j_waddr = tab_clear ? clr_cnt_reg : joint_code;
    assign h_waddr = tab_clear ? clr_cnt_reg : history_code;
    assign f_waddr = tab_clear ? clr_cnt_reg : future_code;

    pih_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_joint_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (j_waddr),
        .wdata (tab_clear ? '0 : j_inc),
        .re    (tab_re),
        .raddr (j_raddr),
        .rdata (j_rdata)
    );

    pih_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_history_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (h_waddr),
        .wdata (tab_clear ? '0 : h_inc),
        .re    (tab_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    pih_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_future_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (f_waddr),
        .wdata (tab_clear ? '0 : f_inc),
        .re    (tab_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // ------------------------------------------------------------------
    // result channel
    // ------------------------------------------------------------------
    assign req.ready         = req_ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.joint_code    = jcode_reg;
    assign rsp.history_code  = hcode_reg;
    assign rsp.future_code   = fcode_reg;
    assign rsp.joint_count   = jcnt_reg;
    assign rsp.history_count = hcnt_reg;
    assign rsp.future_count  = fcnt_reg;
    assign rsp.window_total  = wtot_reg;
    assign rsp.bad_symbol    = bad_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`include "predictive_info_histogram_macros.svh"

    // tables are only written by the zeroing pass or a window update
    `PIH_ASSERT_NOW(a_no_write_idle, state_reg == ST_IDLE, !tab_we)
    // code sequencer only finishes while control waits for it
    `PIH_ASSERT_NOW(a_done_in_code, coder_sts.done, state_reg == ST_CODE)
    // a bad symbol result carries no codes and no counts
    `PIH_ASSERT_NOW(a_bad_zero, rsp.valid && rsp.bad_symbol,
        rsp.joint_code == '0 && rsp.joint_count == '0 && rsp.future_count == '0)
    // a clear request restarts the sweep and zeroes the window total
    `PIH_ASSERT_NEXT(a_clear_start,
        req.valid && req.ready && req.opcode == OP_CLEAR,
        state_reg == ST_CLEAR && clr_cnt_reg == '0 && total_reg == '0)

endmodule

// ----- tb/sv/tb_predictive_info_histogram.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_predictive_info_histogram: self-checking bench for the window histogram
// a clocked driver feeds requests from a pending queue and a clocked monitor
// compares every result, field by field, with a shadow model of the window,
// the three count tables and the window total, across several register settings
// ----------------------------------------------------------------------------
module tb_predictive_info_histogram;
    import pih_pkg::*;

    // geometry of the block as instantiated (default parameters)
    localparam int TBL_SIZE  = 4096;
    localparam int WIN_MAX   = 12;
    localparam int BASE_MAX  = 16;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // opcode value the block must ignore
    localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;

    // quiet time before a register write or the verdict: covers a zeroing pass
    localparam int SETTLE_CYCLES = 4200;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 68;
    localparam int MAX_REPORTS   = 50;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [SYM_W-1:0]  symbol;
        logic              first_of_series;
        logic [RIDX_W-1:0] read_index;
    } hist_req_t;

    typedef struct packed {
        logic [CODE_W-1:0]    joint_code;
        logic [CODE_W-1:0]    history_code;
        logic [CODE_W-1:0]    future_code;
        logic [CNT_OUT_W-1:0] joint_count;
        logic [CNT_OUT_W-1:0] history_count;
        logic [CNT_OUT_W-1:0] future_count;
        logic [CNT_OUT_W-1:0] window_total;
        logic                 bad_symbol;
    } hist_rsp_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pih_req_if req_ch ();
    pih_rsp_if rsp_ch ();

    predictive_info_histogram u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // requests waiting to be sent, and results still owed by the block
    hist_req_t pending_q[$];
    hist_rsp_t owed_rsp_q[$];

    // shadow of the registers as last written
    logic [BASE_CFG_W-1:0] base_sh;
    logic [LEN_CFG_W-1:0]  past_sh;
    logic [LEN_CFG_W-1:0]  fut_sh;

    // shadow of the block state; digit 0 is the newest symbol
    logic [3:0]  win_dig [WIN_MAX];
    int          fill_cnt;
    logic [31:0] joint_tab [TBL_SIZE];
    logic [31:0] hist_tab  [TBL_SIZE];
    logic [31:0] fut_tab   [TBL_SIZE];
    logic [31:0] win_total;

    // idle bursts on both sides; quiet turns new bursts off near the end
    int send_gap;
    int sink_stall;
    bit quiet;
    int series_left;

    int err_cnt;
    int n_req;
    int n_rsp;
    int n_reads;
    int n_bad;
    int n_settings;

    hist_rsp_t want_rsp;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // effective settings, clamped the way the block clamps them
    // ------------------------------------------------------------------
    function automatic int eff_base();
        if (base_sh < 2)
            return 2;
        if (base_sh > BASE_MAX)
            return BASE_MAX;
        return int'(base_sh);
    endfunction

    function automatic int eff_past();
        if (past_sh < 1)
            return 1;
        if (past_sh > WIN_MAX - 1)
            return WIN_MAX - 1;
        return int'(past_sh);
    endfunction

    function automatic int eff_future(input int kp);
        if (fut_sh < 1)
            return 1;
        if (fut_sh > WIN_MAX - kp)
            return WIN_MAX - kp;
        return int'(fut_sh);
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    // base-b code of digits hi down to lo, older digit first; wraps to 12 bits
    function automatic logic [CODE_W-1:0] window_code(input int hi, input int lo, input int b);
        logic [CODE_W-1:0] c;
        c = '0;
        for (int i = hi; i >= lo; i--)
            c = CODE_W'(c * b + win_dig[i]);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // histogram predictor: applies one accepted request to the shadow
    // state and queues the result it owes, if any
    // ------------------------------------------------------------------
    task automatic predict_histogram(input hist_req_t rq);
        int                b;
        int                kp;
        int                kf;
        int                wlen;
        hist_rsp_t         r;
        logic [CODE_W-1:0] jc;
        logic [CODE_W-1:0] hc;
        logic [CODE_W-1:0] fc;
        b    = eff_base();
        kp   = eff_past();
        kf   = eff_future(kp);
        wlen = kp + kf;
        r    = '0;
        if (rq.opcode == OP_READ)
        begin
            // read: codes zero, counts at the index
            r.joint_count   = joint_tab[rq.read_index];
            r.history_count = hist_tab[rq.read_index];
            r.future_count  = fut_tab[rq.read_index];
            r.window_total  = win_total;
            owed_rsp_q.push_back(r);
            n_reads++;
        end
        else if (rq.opcode == OP_CLEAR)
        begin
            // clear keeps the window, zeroes tables and total
            for (int i = 0; i < TBL_SIZE; i++)
            begin
                joint_tab[i] = '0;
                hist_tab[i]  = '0;
                fut_tab[i]   = '0;
            end
            win_total = '0;
        end
        else if (rq.opcode == OP_PUSH)
        begin
            if (rq.first_of_series)
                fill_cnt = 0;
            if (rq.symbol >= b)
            begin
                // bad symbol: flagged, not entered, nothing counted
                r.bad_symbol   = 1'b1;
                r.window_total = win_total;
                owed_rsp_q.push_back(r);
                n_bad++;
            end
            else
            begin
                for (int i = WIN_MAX - 1; i > 0; i--)
                    win_dig[i] = win_dig[i-1];
                win_dig[0] = rq.symbol[3:0];
                if (fill_cnt < WIN_MAX)
                    fill_cnt++;
                // a window that is not yet full gives no result
                if (fill_cnt >= wlen)
                begin
                    jc = window_code(wlen - 1, 0, b);
                    hc = window_code(wlen - 1, kf, b);
                    fc = window_code(kf - 1, 0, b);
                    joint_tab[jc] = sat_inc(joint_tab[jc]);
                    hist_tab[hc]  = sat_inc(hist_tab[hc]);
                    fut_tab[fc]   = sat_inc(fut_tab[fc]);
                    win_total     = sat_inc(win_total);
                    r.joint_code    = jc;
                    r.history_code  = hc;
                    r.future_code   = fc;
                    r.joint_count   = joint_tab[jc];
                    r.history_count = hist_tab[hc];
                    r.future_count  = fut_tab[fc];
                    r.window_total  = win_total;
                    owed_rsp_q.push_back(r);
                end
            end
        end
        // the spare opcode is ignored entirely
    endtask

    // ------------------------------------------------------------------
    // request driver: one item per request, random gaps after acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_histogram(pending_q.pop_front());
                n_req++;
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            // the current request is held until the block takes it
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    req_ch.valid           <= 1'b1;
                    req_ch.opcode          <= pending_q[0].opcode;
                    req_ch.symbol          <= pending_q[0].symbol;
                    req_ch.first_of_series <= pending_q[0].first_of_series;
                    req_ch.read_index      <= pending_q[0].read_index;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // result monitor: compares each accepted result with the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b1;
            sink_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_rsp_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t ns: result with none expected, expected none, actual joint_code 0x%0h",
                                 $time, rsp_ch.joint_code);
                end
                else
                begin
                    want_rsp = owed_rsp_q.pop_front();
                    check_field("joint_code", 32'(want_rsp.joint_code),
                                32'(rsp_ch.joint_code));
                    check_field("history_code", 32'(want_rsp.history_code),
                                32'(rsp_ch.history_code));
                    check_field("future_code", 32'(want_rsp.future_code),
                                32'(rsp_ch.future_code));
                    check_field("joint_count", want_rsp.joint_count, rsp_ch.joint_count);
                    check_field("history_count", want_rsp.history_count, rsp_ch.history_count);
                    check_field("future_count", want_rsp.future_count, rsp_ch.future_count);
                    check_field("window_total", want_rsp.window_total, rsp_ch.window_total);
                    check_field("bad_symbol", 32'(want_rsp.bad_symbol),
                                32'(rsp_ch.bad_symbol));
                    n_rsp++;
                end
            end
            // stall bursts on the result side
            if (sink_stall > 0)
            begin
                sink_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    sink_stall = $urandom_range(1, 19);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic enq(input logic [OPC_W-1:0] op, input int sym, input bit first, input int idx);
        hist_req_t it;
        it.opcode          = op;
        it.symbol          = sym[SYM_W-1:0];
        it.first_of_series = first;
        it.read_index      = idx[RIDX_W-1:0];
        pending_q.push_back(it);
    endtask

    // registers change only while the block is idle
    task automatic write_regs(input int b, input int p, input int f);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_data  <= b[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_PAST;
        cfg_data  <= p[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_FUTURE;
        cfg_data  <= f[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        base_sh = b[BASE_CFG_W-1:0];
        past_sh = p[LEN_CFG_W-1:0];
        fut_sh  = f[LEN_CFG_W-1:0];
        n_settings++;
        @(negedge clk);
    endtask

    // all requests sent, all results back, then room for any trailing work
    task automatic wait_drained();
        @(negedge clk);
        while (pending_q.size() > 0 || req_ch.valid || owed_rsp_q.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly well-formed series of good symbols, with reads, bad symbols,
    // rare clears, spare opcodes and broken series mixed in
    task automatic add_random(input int count);
        hist_req_t it;
        int        roll;
        int        b;
        int        wl;
        b  = eff_base();
        wl = eff_past() + eff_future(eff_past());
        for (int n = 0; n < count; n++)
        begin
            it.opcode          = OP_PUSH;
            it.symbol          = SYM_W'($urandom_range(0, b - 1));
            it.first_of_series = 1'b0;
            it.read_index      = RIDX_W'($urandom_range(0, TBL_SIZE - 1));
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                it.opcode          = OP_CLEAR;
                it.symbol          = SYM_W'($urandom_range(0, 255));
                it.first_of_series = 1'($urandom_range(0, 1));
            end
            else if (roll < 10)
            begin
                // low indexes are where most counts land
                it.opcode          = OP_READ;
                it.symbol          = SYM_W'($urandom_range(0, 255));
                it.first_of_series = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 0)
                    it.read_index = RIDX_W'($urandom_range(0, 15));
            end
            else if (roll < 12)
            begin
                it.opcode          = OP_SPARE;
                it.symbol          = SYM_W'($urandom_range(0, 255));
                it.first_of_series = 1'($urandom_range(0, 1));
            end
            else if (roll < 17)
            begin
                it.symbol          = SYM_W'($urandom_range(b, 255));
                it.first_of_series = ($urandom_range(0, 9) == 0);
            end
            else
            begin
                // new series when the old one ends, or now and then early
                if (series_left == 0 || $urandom_range(0, 49) == 0)
                begin
                    it.first_of_series = 1'b1;
                    series_left = $urandom_range(wl, 3 * wl + 8);
                end
                series_left--;
            end
            pending_q.push_back(it);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int pb;
        int pp;
        int pf;
        rst_n                  = 1'b0;
        cfg_write              = 1'b0;
        cfg_index              = CFG_BASE;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.opcode          = OP_PUSH;
        req_ch.symbol          = '0;
        req_ch.first_of_series = 1'b0;
        req_ch.read_index      = '0;
        rsp_ch.ready           = 1'b1;
        quiet       = 1'b0;
        series_left = 0;
        err_cnt     = 0;
        n_req       = 0;
        n_rsp       = 0;
        n_reads     = 0;
        n_bad       = 0;
        n_settings  = 0;
        // shadow state after reset
        base_sh   = 5'd2;
        past_sh   = 4'd1;
        fut_sh    = 4'd1;
        fill_cnt  = 0;
        win_total = '0;
        for (int i = 0; i < WIN_MAX; i++)
            win_dig[i] = '0;
        for (int i = 0; i < TBL_SIZE; i++)
        begin
            joint_tab[i] = '0;
            hist_tab[i]  = '0;
            fut_tab[i]   = '0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // let the zeroing pass after reset finish
        wait_drained();

        // directed, base 2, one past and one future symbol
        write_regs(2, 1, 1);
        enq(OP_READ, 0, 1'b0, 0);        // empty tables
        enq(OP_PUSH, 0, 1'b1, 0);        // window not yet full
        enq(OP_PUSH, 1, 1'b0, 0);        // first full window
        enq(OP_PUSH, 1, 1'b0, 0);
        enq(OP_PUSH, 2, 1'b0, 0);        // symbol equal to base
        enq(OP_PUSH, 255, 1'b1, 0);      // largest symbol, also restarts the series
        enq(OP_PUSH, 0, 1'b0, 0);
        enq(OP_PUSH, 1, 1'b0, 0);
        enq(OP_READ, 0, 1'b0, TBL_SIZE - 1);
        enq(OP_READ, 0, 1'b0, 1);
        enq(OP_CLEAR, 0, 1'b0, 0);       // window survives the clear
        enq(OP_READ, 0, 1'b0, 1);
        enq(OP_SPARE, 255, 1'b1, TBL_SIZE - 1);
        enq(OP_PUSH, 1, 1'b0, 0);
        enq(OP_PUSH, 0, 1'b0, 0);
        enq(OP_READ, 0, 1'b0, 2);
        wait_drained();

        // directed, base 16 over four digits: codes wrap past the table
        write_regs(16, 2, 2);
        enq(OP_PUSH, 15, 1'b1, 0);
        enq(OP_PUSH, 15, 1'b0, 0);
        enq(OP_PUSH, 15, 1'b0, 0);
        enq(OP_PUSH, 15, 1'b0, 0);
        enq(OP_PUSH, 15, 1'b0, 0);
        enq(OP_READ, 0, 1'b0, TBL_SIZE - 1);
        enq(OP_READ, 0, 1'b0, 255);
        wait_drained();

        // random phases over extreme, clamped and random settings
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin pb = 2;  pp = 11; pf = 1;  end   // longest window, base 2
                1: begin pb = 16; pp = 11; pf = 11; end   // future clamped to fit
                2: begin pb = 2;  pp = 1;  pf = 11; end
                3: begin pb = 0;  pp = 0;  pf = 0;  end   // all clamped up
                4: begin pb = 31; pp = 15; pf = 15; end   // all clamped down
                5: begin pb = 16; pp = 1;  pf = 1;  end
                6: begin pb = 3;  pp = 2;  pf = 3;  end
                7: begin pb = 5;  pp = 3;  pf = 2;  end
                default:
                begin
                    pb = $urandom_range(0, 31);
                    pp = $urandom_range(0, 15);
                    pf = $urandom_range(0, 15);
                end
            endcase
            if (p == PHASES - 1)
                quiet = 1'b1;
            write_regs(pb, pp, pf);
            add_random(PHASE_ITEMS);
            wait_drained();
        end

        $display("run covered %0d requests (%0d reads, %0d bad symbols), %0d results checked",
                 n_req, n_reads, n_bad, n_rsp);
        $display("register settings applied: %0d, failures: %0d", n_settings, err_cnt);
        if (err_cnt == 0 && owed_rsp_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #25_000_000;
        $display("timeout with %0d results still owed", owed_rsp_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pih_pkg.sv
rtl/core/pih_if.sv
rtl/core/pih_ram.sv
rtl/core/pih_coder.sv
rtl/core/predictive_info_histogram.sv
tb/sv/tb_predictive_info_histogram.sv
